// ===== rtl/kufa_pkg.sv =====
// Shared types and constants for the Kruskal union-find accumulator.
package kufa_pkg;

    // Field widths of the edge and result words
    localparam int NODE_IDX_W   = 8;
    localparam int WEIGHT_W     = 17;
    localparam int SUM_W        = 26;
    localparam int COUNT_W      = 8;
    localparam int NODE_COUNT_W = 9;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;
    localparam logic [SUM_W-1:0]        SUM_MAX          = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0]      COUNT_MAX        = {COUNT_W{1'b1}};

    // Command codes
    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_EDGE  = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [NODE_IDX_W-1:0] edge_from;
        logic [NODE_IDX_W-1:0] edge_to;
        logic [WEIGHT_W-1:0]   weight;
    } edge_word_t;

    typedef struct packed {
        logic               accepted;
        logic [SUM_W-1:0]   total;
        logic [COUNT_W-1:0] joined_count;
        logic               done_res;
    } res_word_t;

endpackage

// ===== rtl/kufa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kufa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/kruskal_union_find_accumulator.sv =====
// Kruskal spanning-tree edge acceptance over a disjoint-set forest in RAM.
//
// Edge channel (edge_valid, edge_stall, edge_word): one word per edge or clear
// command. Result channel (res_valid, res_stall, res_word): exactly one word per
// edge word, in order. cfg_wr_en/cfg_wr_data write node_count; the user must
// write it only while idle, which the block itself does not enforce. A word is
// taken only in the idle state; the block then works on it alone. For each
// endpoint an edge walks the parent chain, one RAM read per cycle, then
// rewrites the walked path to point at the root, one RAM write per cycle.
// An ignored edge yields its result in the cycle after it is taken. A clear
// command yields its result in the cycle after it is taken and then sweeps the
// forest back to identity, during which no word is taken. Reset starts the
// same sweep. The single result register holds while res_stall is high; no
// new edge word is taken until the waiting result is taken or leaves in the
// same cycle.
module kruskal_union_find_accumulator
    import kufa_pkg::*;
#(
    parameter int MAX_NODES = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    edge_valid,
    output logic                    edge_stall,
    input  edge_word_t              edge_word,
    output logic                    res_valid,
    input  logic                    res_stall,
    output res_word_t               res_word,
    input  logic                    cfg_wr_en,
    input  logic [NODE_COUNT_W-1:0] cfg_wr_data
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int NU_W   = ($clog2(MAX_NODES + 1) > NODE_COUNT_W) ?
                            $clog2(MAX_NODES + 1) : NODE_COUNT_W;
    localparam logic [NU_W-1:0]   MAX_NU    = NU_W'(MAX_NODES);
    localparam logic [NU_W-1:0]   MIN_NU    = NU_W'(2);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);

    typedef enum logic [5:0] {
        ST_SWEEP  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_FIND   = 6'b000100,
        ST_COMP   = 6'b001000,
        ST_LOOKUP = 6'b010000,
        ST_LINK   = 6'b100000
    } state_t;

    // Control state
    state_t                  state_reg,      state_next;
    logic [NODE_W-1:0]       sweep_reg,      sweep_next;
    logic                    phase_reg,      phase_next;
    logic [SUM_W-1:0]        weight_sum_reg, weight_sum_next;
    logic [COUNT_W-1:0]      join_count_reg, join_count_next;
    logic [NODE_COUNT_W-1:0] node_count_reg;
    logic                    res_valid_reg,  res_valid_next;

    // Working payload
    logic [NODE_W-1:0]       r_reg,     r_next;
    logic [NODE_W-1:0]       cur_reg,   cur_next;
    logic [NODE_W-1:0]       start_reg, start_next;
    logic [NODE_W-1:0]       ra_reg,    ra_next;
    logic [NODE_W-1:0]       b_reg,     b_next;
    logic [WEIGHT_W-1:0]     wgt_reg,   wgt_next;
    res_word_t               res_word_reg, res_word_next;

    // Parent table port
    logic                    rd_en;
    logic [NODE_W-1:0]       rd_addr;
    logic [NODE_W-1:0]       rd_data;
    logic                    wr_en;
    logic [NODE_W-1:0]       wr_addr;
    logic [NODE_W-1:0]       wr_data;

    logic [NU_W-1:0]         ncount_ext;
    logic [NU_W-1:0]         n_use;
    logic                    edge_take;
    logic                    edge_ok;
    logic                    tree_full;
    logic                    find_done;
    logic                    res_load;
    logic [SUM_W:0]          sum_ext;
    logic [SUM_W-1:0]        sum_upd;
    logic [COUNT_W-1:0]      cnt_upd;

    // Tree complete once count reaches nodes in use minus one
    function automatic logic is_full(input logic [COUNT_W-1:0] cnt,
                                     input logic [NU_W-1:0]    n);
        return (NU_W'(cnt) + NU_W'(1)) >= n;
    endfunction

    kufa_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Saturate node count into 2..MAX_NODES
    always_comb
    begin
        ncount_ext = NU_W'(node_count_reg);
        if (ncount_ext < MIN_NU)
        begin
            n_use = MIN_NU;
        end
        else if (ncount_ext > MAX_NU)
        begin
            n_use = MAX_NU;
        end
        else
        begin
            n_use = ncount_ext;
        end
    end

    assign edge_stall = (state_reg != ST_IDLE) || (res_valid_reg && res_stall);
    assign edge_take  = edge_valid && !edge_stall;
    assign edge_ok    = (NU_W'(edge_word.edge_from) < n_use) &&
                        (NU_W'(edge_word.edge_to) < n_use);
    assign tree_full  = is_full(join_count_reg, n_use);

    // Saturating accumulate of an accepted edge
    assign sum_ext = {1'b0, weight_sum_reg} + (SUM_W + 1)'(wgt_reg);
    assign sum_upd = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    assign cnt_upd = (join_count_reg == COUNT_MAX) ? join_count_reg :
                     join_count_reg + COUNT_W'(1);

    // Sequencer: sweep, take word, walk chains, compress, link
    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        phase_next      = phase_reg;
        weight_sum_next = weight_sum_reg;
        join_count_next = join_count_reg;
        r_next          = r_reg;
        cur_next        = cur_reg;
        start_next      = start_reg;
        ra_next         = ra_reg;
        b_next          = b_reg;
        wgt_next        = wgt_reg;
        rd_en           = 1'b0;
        rd_addr         = r_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = r_reg;
        res_load        = 1'b0;
        res_word_next   = res_word_reg;
        find_done       = 1'b0;

        case (state_reg)
            ST_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
                wr_data = sweep_reg;
                if (sweep_reg == LAST_NODE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + NODE_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (edge_take)
                begin
                    if (edge_word.cmd == CMD_CLEAR)
                    begin
                        weight_sum_next = '0;
                        join_count_next = '0;
                        res_load        = 1'b1;
                        res_word_next   = '0;
                        sweep_next      = '0;
                        state_next      = ST_SWEEP;
                    end
                    else if (!tree_full && edge_ok)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = NODE_W'(edge_word.edge_from);
                        r_next     = NODE_W'(edge_word.edge_from);
                        start_next = NODE_W'(edge_word.edge_from);
                        phase_next = 1'b0;
                        b_next     = NODE_W'(edge_word.edge_to);
                        wgt_next   = edge_word.weight;
                        state_next = ST_FIND;
                    end
                    else
                    begin
                        res_load                   = 1'b1;
                        res_word_next.accepted     = 1'b0;
                        res_word_next.total        = weight_sum_reg;
                        res_word_next.joined_count = join_count_reg;
                        res_word_next.done_res     = tree_full;
                    end
                end
            end
            ST_FIND:
            begin
                if (rd_data == r_reg)
                begin
                    if (start_reg == r_reg)
                    begin
                        find_done = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = start_reg;
                        cur_next   = start_reg;
                        state_next = ST_COMP;
                    end
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = rd_data;
                    r_next  = rd_data;
                end
            end
            ST_COMP:
            begin
                // Point the current node at the root, advance along the old link
                wr_en = 1'b1;
                if (rd_data == r_reg)
                begin
                    find_done = 1'b1;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_data;
                    cur_next = rd_data;
                end
            end
            ST_LOOKUP:
            begin
                rd_en      = 1'b1;
                rd_addr    = b_reg;
                r_next     = b_reg;
                start_next = b_reg;
                state_next = ST_FIND;
            end
            ST_LINK:
            begin
                res_load   = 1'b1;
                state_next = ST_IDLE;
                if (ra_reg != r_reg)
                begin
                    wr_en                      = 1'b1;
                    wr_addr                    = ra_reg;
                    wr_data                    = r_reg;
                    weight_sum_next            = sum_upd;
                    join_count_next            = cnt_upd;
                    res_word_next.accepted     = 1'b1;
                    res_word_next.total        = sum_upd;
                    res_word_next.joined_count = cnt_upd;
                    res_word_next.done_res     = is_full(cnt_upd, n_use);
                end
                else
                begin
                    res_word_next.accepted     = 1'b0;
                    res_word_next.total        = weight_sum_reg;
                    res_word_next.joined_count = join_count_reg;
                    res_word_next.done_res     = tree_full;
                end
            end
            default:
            begin
                sweep_next = '0;
                state_next = ST_SWEEP;
            end
        endcase

        // Root found: move on to the second endpoint or to the link step
        if (find_done)
        begin
            if (!phase_reg)
            begin
                ra_next    = r_reg;
                phase_next = 1'b1;
                state_next = ST_LOOKUP;
            end
            else
            begin
                state_next = ST_LINK;
            end
        end
    end

    // Hold the result word until taken
    assign res_valid_next = res_load || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_reg      <= '0;
            phase_reg      <= 1'b0;
            weight_sum_reg <= '0;
            join_count_reg <= '0;
            node_count_reg <= NODE_COUNT_RESET;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            phase_reg      <= phase_next;
            weight_sum_reg <= weight_sum_next;
            join_count_reg <= join_count_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        cur_reg   <= cur_next;
        start_reg <= start_next;
        ra_reg    <= ra_next;
        b_reg     <= b_next;
        wgt_reg   <= wgt_next;
        if (res_load)
        begin
            res_word_reg <= res_word_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

`ifndef SYNTHESIS
    // A word is taken only in the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        !edge_stall |-> (state_reg == ST_IDLE))
    else $error("edge word taken outside idle state");

    // A new result appears only after idle or the link step
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !$past(res_valid)) |->
            ($past(state_reg) == ST_IDLE || $past(state_reg) == ST_LINK))
    else $error("result produced from an unexpected state");

    // The join count only steps by one or clears
    assert property (@(posedge clk) disable iff (!rst_n)
        (join_count_reg != $past(join_count_reg)) |->
            (join_count_reg == '0 ||
             join_count_reg == $past(join_count_reg) + COUNT_W'(1)))
    else $error("join count changed by an illegal step");

    // An accepted edge always carries a nonzero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.accepted) |-> (res_word.joined_count != '0))
    else $error("accepted edge with zero join count");
`endif

endmodule

// ===== tb/sv/kufa_span_checker.sv =====
// Checker for the Kruskal union-find accumulator: predicts and compares result words.
module kufa_span_checker
    import kufa_pkg::*;
#(
    parameter int MAX_NODES = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    edge_valid,
    input  logic                    edge_stall,
    input  edge_word_t              edge_word,
    input  logic                    res_valid,
    input  logic                    res_stall,
    input  res_word_t               res_word,
    input  logic                    cfg_wr_en,
    input  logic [NODE_COUNT_W-1:0] cfg_wr_data,
    output int                      fail_count,
    output int                      pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow forest, running sum and join count
    logic [NODE_IDX_W-1:0]   forest [MAX_NODES];
    logic [SUM_W-1:0]        weight_sum;
    logic [COUNT_W-1:0]      join_count;
    logic [NODE_COUNT_W-1:0] node_reg;

    res_word_t expected_results [$];

    // Return the forest to identity and zero the accumulators
    function automatic void clear_forest();
        for (int i = 0; i < MAX_NODES; i++)
        begin
            forest[i] = NODE_IDX_W'(i);
        end
        weight_sum = '0;
        join_count = '0;
    endfunction

    // Saturate the raw register to the usable node range
    function automatic int unsigned span_limit();
        int unsigned n;
        n = node_reg;
        if (n < 2)
            n = 2;
        if (n > MAX_NODES)
            n = MAX_NODES;
        return n;
    endfunction

    // Walk to the root, then point every visited node straight at it
    function automatic logic [NODE_IDX_W-1:0] find_root(input logic [NODE_IDX_W-1:0] v);
        logic [NODE_IDX_W-1:0] r;
        logic [NODE_IDX_W-1:0] cur;
        logic [NODE_IDX_W-1:0] nxt;
        int                    steps;
        r = v;
        steps = 0;
        while (steps < MAX_NODES && forest[r] != r)
        begin
            r = forest[r];
            steps++;
        end
        cur = v;
        steps = 0;
        while (cur != r && steps < MAX_NODES)
        begin
            nxt = forest[cur];
            forest[cur] = r;
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    // Apply one edge word to the shadow state and build its result word
    function automatic res_word_t predict_join(input edge_word_t w);
        res_word_t             r;
        int unsigned           n;
        logic [NODE_IDX_W-1:0] ra;
        logic [NODE_IDX_W-1:0] rb;
        r.accepted = 1'b0;
        if (w.cmd == CMD_CLEAR)
        begin
            clear_forest();
        end
        else
        begin
            n = span_limit();
            if (join_count < n - 1 && w.edge_from < n && w.edge_to < n)
            begin
                ra = find_root(w.edge_from);
                rb = find_root(w.edge_to);
                if (ra != rb)
                begin
                    forest[ra] = rb;
                    if (weight_sum > SUM_MAX - w.weight)
                        weight_sum = SUM_MAX;
                    else
                        weight_sum = weight_sum + w.weight;
                    if (join_count != COUNT_MAX)
                        join_count = join_count + 1'b1;
                    r.accepted = 1'b1;
                end
            end
        end
        r.total        = weight_sum;
        r.joined_count = join_count;
        r.done_res     = (join_count >= span_limit() - 1);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
        end
    endtask

    // Track config writes, queue predictions, compare results in order
    always @(posedge clk or negedge rst_n)
    begin
        res_word_t want;
        res_word_t guess;
        if (!rst_n)
        begin
            clear_forest();
            node_reg = NODE_COUNT_RESET;
            expected_results.delete();
            fail_count = 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                node_reg = cfg_wr_data;
            if (edge_valid && !edge_stall)
            begin
                guess = predict_join(edge_word);
                expected_results.insert(expected_results.size(), guess);
            end
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result word with none waiting, expected none, got %0d %0d %0d %0d",
                             $time, res_word.accepted, res_word.total,
                             res_word.joined_count, res_word.done_res);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("accepted", want.accepted, res_word.accepted);
                    check_field("total", want.total, res_word.total);
                    check_field("joined_count", want.joined_count, res_word.joined_count);
                    check_field("done_res", want.done_res, res_word.done_res);
                end
            end
            pending_count <= expected_results.size();
        end
    end

endmodule

// ===== tb/sv/kruskal_union_find_accumulator_test.sv =====
// Top of the Kruskal union-find accumulator testbench: stimulus, stalls and verdict.
module kruskal_union_find_accumulator_test
    import kufa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NODES      = 256;
    localparam int SWEEP_GUARD    = MAX_NODES + 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int WORD_TARGET    = 850;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    edge_valid  = 1'b0;
    logic                    edge_stall;
    edge_word_t              edge_word   = '0;
    logic                    res_valid;
    logic                    res_stall   = 1'b0;
    res_word_t               res_word;
    logic                    cfg_wr_en   = 1'b0;
    logic [NODE_COUNT_W-1:0] cfg_wr_data = '0;

    int fail_count;
    int pending_count;
    int words_sent  = 0;
    int nodes_now   = MAX_NODES;
    int idle_cycles = 0;
    bit steady      = 1'b0;

    kruskal_union_find_accumulator #(
        .MAX_NODES(MAX_NODES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_valid (edge_valid),
        .edge_stall (edge_stall),
        .edge_word  (edge_word),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_word   (res_word),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    kufa_span_checker #(
        .MAX_NODES(MAX_NODES)
    ) span_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_stall   (edge_stall),
        .edge_word    (edge_word),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res_word     (res_word),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // End the run when no word moves on either channel for too long
    always @(posedge clk)
    begin
        if ((edge_valid && !edge_stall) || (res_valid && !res_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("kruskal_union_find_accumulator regression: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stall the result channel a random number of cycles per word
    initial
    begin
        int hold;
        wait (rst_n);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 15);
            if (hold != 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    function automatic edge_word_t edge_of(input logic [7:0] a, input logic [7:0] b,
                                           input logic [16:0] w);
        edge_word_t e;
        e.cmd       = CMD_EDGE;
        e.edge_from = a;
        e.edge_to   = b;
        e.weight    = w;
        return e;
    endfunction

    // Idle a random gap, then hold the word until it is taken
    task automatic send_word(input edge_word_t w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            edge_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        edge_valid <= 1'b1;
        edge_word  <= w;
        do @(posedge clk); while (edge_stall);
        words_sent++;
    endtask

    // Clear with junk in the edge fields, which the block must ignore
    task automatic send_clear();
        edge_word_t c;
        c.cmd       = CMD_CLEAR;
        c.edge_from = NODE_IDX_W'($urandom_range(0, 255));
        c.edge_to   = NODE_IDX_W'($urandom_range(0, 255));
        c.weight    = WEIGHT_W'($urandom_range(0, 131071));
        send_word(c);
    endtask

    // Drop valid, wait for every result, then let a clear sweep finish
    task automatic drain_results();
        edge_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (SWEEP_GUARD) @(posedge clk);
    endtask

    task automatic set_node_count(input logic [NODE_COUNT_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        nodes_now = (value < 2) ? 2 : (value > MAX_NODES) ? MAX_NODES : value;
    endtask

    // One setting: mostly tree-building edges in falling weight order, some noise
    task automatic run_random_phase();
        logic [7:0]  order [256];
        logic [7:0]  tmp;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [16:0] w;
        int          step;
        int          n_edges;
        int          reach;
        int          roll;
        int          j;
        case ($urandom_range(0, 7))
            0: set_node_count(9'd2);
            1: set_node_count(9'd3);
            2: set_node_count(NODE_COUNT_W'($urandom_range(4, 16)));
            3: set_node_count(NODE_COUNT_W'($urandom_range(17, 255)));
            4: set_node_count(9'd256);
            5: set_node_count(NODE_COUNT_W'($urandom_range(0, 511)));
            6: set_node_count(NODE_COUNT_W'($urandom_range(2, 64)));
            default: ;
        endcase
        steady = ($urandom_range(0, 3) == 0);

        // shuffle the order in which nodes join the tree
        for (int k = 0; k < 256; k++)
        begin
            order[k] = NODE_IDX_W'(k);
        end
        for (int k = nodes_now - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end

        if ($urandom_range(0, 4) != 0)
            send_clear();
        reach = 1;
        w = WEIGHT_W'($urandom_range(0, 131071));
        n_edges = $urandom_range(10, 40) + (nodes_now * 5) / 4;
        if (n_edges > 330)
            n_edges = 330;
        // stop near the word budget
        if (n_edges > WORD_TARGET - words_sent)
            n_edges = WORD_TARGET - words_sent;

        repeat (n_edges)
        begin
            step = $urandom_range(0, 700);
            w = (w > step) ? WEIGHT_W'(w - step) : '0;
            roll = $urandom_range(0, 99);
            if (roll < 55 && reach < nodes_now)
            begin
                // attach a fresh node to the part already spanned
                a = order[$urandom_range(0, reach - 1)];
                b = order[reach];
                reach++;
                if ($urandom_range(0, 1) != 0)
                begin
                    tmp = a;
                    a = b;
                    b = tmp;
                end
                send_word(edge_of(a, b, w));
            end
            else if (roll < 88)
            begin
                a = NODE_IDX_W'($urandom_range(0, nodes_now - 1));
                b = NODE_IDX_W'($urandom_range(0, nodes_now - 1));
                send_word(edge_of(a, b, w));
            end
            else if (roll < 94)
            begin
                // endpoints anywhere, often out of range
                a = NODE_IDX_W'($urandom_range(0, 255));
                b = NODE_IDX_W'($urandom_range(0, 255));
                send_word(edge_of(a, b, w));
            end
            else if (roll < 98)
            begin
                // break the weight order
                a = NODE_IDX_W'($urandom_range(0, nodes_now - 1));
                b = NODE_IDX_W'($urandom_range(0, nodes_now - 1));
                send_word(edge_of(a, b, WEIGHT_W'($urandom_range(0, 131071))));
            end
            else
            begin
                send_clear();
                reach = 1;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: full 256 nodes
        send_word(edge_of(8'd0, 8'd255, 17'h1FFFF));
        send_word(edge_of(8'd255, 8'd0, 17'h1FFFF));
        send_word(edge_of(8'd7, 8'd7, 17'd100));
        send_word(edge_of(8'd1, 8'd2, 17'd0));
        send_word(edge_of(8'd2, 8'd0, 17'hFFFF));
        send_word(edge_of(8'd255, 8'd255, 17'd1));
        send_clear();
        send_word(edge_of(8'd0, 8'd255, 17'h10000));

        // two nodes: one join completes the tree
        set_node_count(9'd2);
        send_clear();
        send_word(edge_of(8'd0, 8'd1, 17'd5000));
        send_word(edge_of(8'd1, 8'd0, 17'd4000));
        send_word(edge_of(8'd0, 8'd2, 17'd3000));
        send_word(edge_of(8'd255, 8'd0, 17'd2000));

        // register below range saturates to two
        set_node_count(9'd0);
        send_word(edge_of(8'd0, 8'd1, 17'd1000));
        send_clear();
        send_word(edge_of(8'd1, 8'd0, 17'd900));

        // register above range saturates to the maximum
        set_node_count(9'h1FF);
        send_word(edge_of(8'd1, 8'd2, 17'd800));
        send_word(edge_of(8'd0, 8'd2, 17'd700));

        // shrink below the joins already made
        set_node_count(9'd3);
        send_word(edge_of(8'd2, 8'd0, 17'd600));
        send_word(edge_of(8'd170, 8'd85, 17'h15555));

        set_node_count(9'd1);
        send_clear();
        send_word(edge_of(8'd1, 8'd0, 17'h0AAAA));

        while (words_sent < WORD_TARGET)
        begin
            run_random_phase();
        end

        steady = 1'b0;
        drain_results();
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("kruskal_union_find_accumulator regression: pass");
        end
        else
        begin
            $display("kruskal_union_find_accumulator regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kufa_pkg.sv
rtl/kufa_ram.sv
rtl/kruskal_union_find_accumulator.sv
tb/sv/kufa_span_checker.sv
tb/sv/kruskal_union_find_accumulator_test.sv
